/* src/preamble_length_frame_deframer_top_macros.svh */
// Assertion macros used by the checker file.
`ifndef PREAMBLE_LENGTH_FRAME_DEFRAMER_TOP_MACROS_SVH
`define PREAMBLE_LENGTH_FRAME_DEFRAMER_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PLFD_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("plfd assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define PLFD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("plfd assertion failed");

`endif

/* src/plfd_pkg.sv */
`timescale 1ns / 1ps
package plfd_pkg;

  localparam int CONNECTIONS = 4;
  localparam int CONN_W      = (CONNECTIONS > 1) ? $clog2(CONNECTIONS) : 1;

  localparam logic [2:0] PH_HANDSHAKE = 3'd0;
  localparam logic [2:0] PH_LEN_HIGH  = 3'd1;
  localparam logic [2:0] PH_LEN_LOW   = 3'd2;
  localparam logic [2:0] PH_PAYLOAD   = 3'd3;
  localparam logic [2:0] PH_CLOSING   = 3'd4;

  localparam logic [1:0] KIND_PAYLOAD      = 2'd0;
  localparam logic [1:0] KIND_REFUSED      = 2'd1;
  localparam logic [1:0] KIND_UNRECOGNIZED = 2'd2;
  localparam logic [1:0] KIND_MISMATCH     = 2'd3;

  localparam logic [7:0] HS_FIRST  = 8'h57;
  localparam logic [7:0] HS_SECOND = 8'h2E;
  localparam logic [7:0] HS_ACCEPT = 8'h19;
  localparam logic [7:0] HS_REFUSE = 8'h18;

  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 16;

  typedef struct packed {
    logic [2:0]  phase;
    logic [1:0]  hs_count;
    logic [15:0] hs_bytes;
    logic [7:0]  frame_high;
    logic [15:0] frame_remaining;
    logic [15:0] frame_length;
    logic [31:0] msg_total;
    logic [31:0] msg_count;
  } conn_state_t;

endpackage

/* src/preamble_length_frame_deframer_top.sv */
// Receive deframer for several connections, one byte per transfer.
// Input channel: tuser carries the command (0 byte, 1 reset of that
// connection's receive state), tdata the connection index and the byte.
// Output channel: tuser carries the result kind (payload, refused,
// unrecognised handshake, size mismatch), tdata the connection and the
// payload byte, tlast marks the final byte of a complete message.
// Each input transfer produces zero or one output transfer.
// A byte is held in an input register; the per-connection state is read,
// updated and written back as the result lands in the output register.
// One transfer per cycle is sustained while out_tready stays high, set by
// the single read-modify-write of the per-connection state registers.
// While the receiver stalls with a result waiting, the output register holds
// it, the input register takes at most one more transfer and in_tready then
// stays low. After rst_n every connection awaits its handshake.
`timescale 1ns / 1ps
module preamble_length_frame_deframer_top (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [plfd_pkg::IN_TDATA_W-1:0]     in_tdata,   // connection[1:0], rx_byte[9:2]
  input  logic                                in_tuser,   // command[0]
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [plfd_pkg::OUT_TDATA_W-1:0]    out_tdata,  // source_connection[1:0], payload_byte[9:2]
  output logic [1:0]                          out_tuser,  // kind[1:0]
  output logic                                out_tlast
);
  import plfd_pkg::*;

  logic        s1_valid_r;
  logic        s1_cmd_r;
  logic [1:0]  s1_conn_r;
  logic [7:0]  s1_byte_r;
  logic        s1_adv;

  conn_state_t st_r [CONNECTIONS];
  conn_state_t cur;
  conn_state_t st_nxt;
  logic        st_we;

  logic [CONN_W-1:0] idx;
  logic              in_range;

  logic        res_valid;
  logic [1:0]  res_kind;
  logic [7:0]  res_byte;
  logic        res_last;

  logic [15:0] len;
  logic [32:0] sum;
  logic [31:0] total_upd;
  logic [31:0] cnt_inc;
  logic [15:0] rem;
  logic        hs_match;

  logic        out_valid_r;
  logic [1:0]  out_conn_r;
  logic [1:0]  out_kind_r;
  logic [7:0]  out_byte_r;
  logic        out_last_r;

  assign s1_adv    = !out_valid_r || out_tready;
  assign in_tready = !s1_valid_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
    if (in_tready && in_tvalid) begin
      s1_cmd_r  <= in_tuser;
      s1_conn_r <= in_tdata[1:0];
      s1_byte_r <= in_tdata[9:2];
    end
  end

  assign idx      = CONN_W'(s1_conn_r);
  assign in_range = (32'(s1_conn_r) < CONNECTIONS);
  assign cur      = st_r[idx];
  assign len      = {cur.frame_high, s1_byte_r};
  assign sum      = {1'b0, cur.msg_count} + {17'b0, len};
  assign hs_match = (cur.hs_bytes == {HS_FIRST, HS_SECOND});
  assign cnt_inc  = cur.msg_count + 32'd1;
  assign rem      = cur.frame_remaining - 16'd1;

  always_comb begin
    total_upd = cur.msg_total;
    if (cur.msg_count < 32'd4) begin
      total_upd = cur.msg_total | ({24'b0, s1_byte_r} << {cur.msg_count[1:0], 3'b000});
    end
  end

  always_comb begin
    st_nxt    = cur;
    st_we     = 1'b0;
    res_valid = 1'b0;
    res_kind  = KIND_PAYLOAD;
    res_byte  = 8'd0;
    res_last  = 1'b0;
    if (s1_valid_r && s1_adv && in_range) begin
      st_we = 1'b1;
      if (s1_cmd_r) begin
        st_nxt = '0;
      end else begin
        unique case (cur.phase)
          PH_HANDSHAKE: begin
            if (cur.hs_count < 2'd2) begin
              st_nxt.hs_bytes = {cur.hs_bytes[7:0], s1_byte_r};
              st_nxt.hs_count = cur.hs_count + 2'd1;
            end else begin
              st_nxt.hs_count = 2'd0;
              st_nxt.hs_bytes = 16'd0;
              if (hs_match && s1_byte_r == HS_ACCEPT) begin
                st_nxt.phase = PH_LEN_HIGH;
              end else if (hs_match && s1_byte_r == HS_REFUSE) begin
                st_nxt.phase = PH_CLOSING;
                res_valid    = 1'b1;
                res_kind     = KIND_REFUSED;
              end else begin
                res_valid = 1'b1;
                res_kind  = KIND_UNRECOGNIZED;
              end
            end
          end
          PH_LEN_HIGH: begin
            st_nxt.frame_high = s1_byte_r;
            st_nxt.phase      = PH_LEN_LOW;
          end
          PH_LEN_LOW: begin
            st_nxt.frame_high = 8'd0;
            if (len == 16'd0) begin
              st_nxt.phase = PH_LEN_HIGH;
            end else if ((cur.msg_count == 32'd0 && len < 16'd4) ||
                         (cur.msg_count != 32'd0 && sum > {1'b0, cur.msg_total})) begin
              st_nxt.phase = PH_CLOSING;
              res_valid    = 1'b1;
              res_kind     = KIND_MISMATCH;
            end else begin
              st_nxt.frame_length    = len;
              st_nxt.frame_remaining = len;
              st_nxt.phase           = PH_PAYLOAD;
            end
          end
          PH_PAYLOAD: begin
            st_nxt.msg_total = total_upd;
            if (cur.msg_count == 32'd3 &&
                (total_upd[31] || total_upd < {16'b0, cur.frame_length})) begin
              st_nxt.phase = PH_CLOSING;
              res_valid    = 1'b1;
              res_kind     = KIND_MISMATCH;
            end else begin
              st_nxt.msg_count = cnt_inc;
              if (cnt_inc >= 32'd4 && cnt_inc == total_upd) begin
                res_last         = 1'b1;
                st_nxt.msg_count = 32'd0;
                st_nxt.msg_total = 32'd0;
              end
              st_nxt.frame_remaining = rem;
              if (rem == 16'd0) begin
                st_nxt.phase = PH_LEN_HIGH;
              end
              res_valid = 1'b1;
              res_kind  = KIND_PAYLOAD;
              res_byte  = s1_byte_r;
            end
          end
          default: begin
            st_we = 1'b0;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CONNECTIONS; i++) begin
        st_r[i] <= '0;
      end
    end else if (st_we) begin
      st_r[idx] <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= res_valid;
    end
    if (s1_adv && res_valid) begin
      out_conn_r <= s1_conn_r;
      out_kind_r <= res_kind;
      out_byte_r <= res_byte;
      out_last_r <= res_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(OUT_TDATA_W - 10)'(0), out_byte_r, out_conn_r};
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;

endmodule

/* src/plfd_checker.sv */
`timescale 1ns / 1ps
`include "preamble_length_frame_deframer_top_macros.svh"
module plfd_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [plfd_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic [1:0]                       out_tuser,
  input logic                             out_tlast
);
  import plfd_pkg::*;

  `PLFD_ASSERT_IMPLY(a_nonpayload_zero, clk, rst_n,
    out_tvalid && out_tuser != KIND_PAYLOAD, out_tdata[9:2] == 8'd0)
  `PLFD_ASSERT_IMPLY(a_last_on_payload, clk, rst_n,
    out_tvalid && out_tlast, out_tuser == KIND_PAYLOAD)
  `PLFD_ASSERT_IMPLY(a_pad_zero, clk, rst_n,
    out_tvalid, out_tdata[OUT_TDATA_W-1:10] == '0)
  `PLFD_ASSERT_NEXT(a_stall_hold, clk, rst_n,
    out_tvalid && !out_tready,
    out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast))

endmodule

bind preamble_length_frame_deframer_top plfd_checker u_plfd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

/* dv/preamble_length_frame_deframer_top_tb.sv */
`timescale 1ns / 1ps
module preamble_length_frame_deframer_top_tb;
  import plfd_pkg::*;

  localparam int IDLE_LIMIT   = 1000;
  localparam int RANDOM_ITEMS = 1100;
  localparam int HOLD_CYCLES  = 300;
  localparam int DIR_ROWS     = 24;

  typedef struct packed {
    logic [1:0] conn;
    logic [1:0] kind;
    logic [7:0] data;
    logic       last;
  } deframe_result_t;

  typedef struct packed {
    logic       cmd;
    logic [7:0] rx;
  } script_byte_t;

  typedef struct packed {
    logic       cmd;
    logic [1:0] conn;
    logic [7:0] rx;
    logic       typed;
    logic       has_res;
    logic [1:0] kind;
  } dir_row_t;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic                   in_tuser   = 1'b0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [1:0]             out_tuser;
  logic                   out_tlast;

  conn_state_t     link_st [CONNECTIONS];
  deframe_result_t expected_results [$];
  script_byte_t    conn_script [CONNECTIONS][$];

  int errors      = 0;
  int idle_cycles = 0;
  int send_count  = 0;
  int recv_count  = 0;
  int live_items  = 0;
  bit hold_req    = 1'b0;
  bit send_calm   = 1'b0;
  bit recv_calm   = 1'b0;

  // Refused, unrecognised, zero-length frame, short first frame and a negative size.
  dir_row_t dir_rows [DIR_ROWS] = '{
    '{1'b0, 2'd0, HS_FIRST,  1'b0, 1'b0, KIND_PAYLOAD},
    '{1'b0, 2'd0, HS_SECOND, 1'b0, 1'b0, KIND_PAYLOAD},
    '{1'b0, 2'd0, HS_REFUSE, 1'b1, 1'b1, KIND_REFUSED},
    '{1'b0, 2'd0, 8'hFF,     1'b1, 1'b0, KIND_PAYLOAD},
    '{1'b1, 2'd0, 8'hFF,     1'b1, 1'b0, KIND_PAYLOAD},
    '{1'b0, 2'd1, 8'h00,     1'b0, 1'b0, KIND_PAYLOAD},
    '{1'b0, 2'd1, 8'hFF,     1'b0, 1'b0, KIND_PAYLOAD},
    '{1'b0, 2'd1, HS_ACCEPT, 1'b1, 1'b1, KIND_UNRECOGNIZED},
    '{1'b0, 2'd1, HS_FIRST,  1'b0, 1'b0, KIND_PAYLOAD},
    '{1'b0, 2'd1, HS_SECOND, 1'b0, 1'b0, KIND_PAYLOAD},
    '{1'b0, 2'd1, HS_ACCEPT, 1'b1, 1'b0, KIND_PAYLOAD},
    '{1'b0, 2'd1, 8'h00,     1'b0, 1'b0, KIND_PAYLOAD},
    '{1'b0, 2'd1, 8'h00,     1'b1, 1'b0, KIND_PAYLOAD},
    '{1'b0, 2'd1, 8'h00,     1'b0, 1'b0, KIND_PAYLOAD},
    '{1'b0, 2'd1, 8'h02,     1'b1, 1'b1, KIND_MISMATCH},
    '{1'b0, 2'd3, HS_FIRST,  1'b0, 1'b0, KIND_PAYLOAD},
    '{1'b0, 2'd3, HS_SECOND, 1'b0, 1'b0, KIND_PAYLOAD},
    '{1'b0, 2'd3, HS_ACCEPT, 1'b0, 1'b0, KIND_PAYLOAD},
    '{1'b0, 2'd3, 8'h00,     1'b0, 1'b0, KIND_PAYLOAD},
    '{1'b0, 2'd3, 8'h04,     1'b0, 1'b0, KIND_PAYLOAD},
    '{1'b0, 2'd3, 8'hFF,     1'b0, 1'b0, KIND_PAYLOAD},
    '{1'b0, 2'd3, 8'hFF,     1'b0, 1'b0, KIND_PAYLOAD},
    '{1'b0, 2'd3, 8'hFF,     1'b0, 1'b0, KIND_PAYLOAD},
    '{1'b0, 2'd3, 8'hFF,     1'b1, 1'b1, KIND_MISMATCH}
  };

  always #2 clk = ~clk;

  preamble_length_frame_deframer_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  function automatic bit deframe_byte(input logic cmd, input logic [1:0] c, input logic [7:0] b,
                                      output deframe_result_t res, output bit skipped);
    logic [15:0] len;
    logic [31:0] n;
    logic [32:0] reach;
    res     = '{conn: c, kind: KIND_PAYLOAD, data: 8'h00, last: 1'b0};
    skipped = 1'b0;
    if (cmd) begin
      link_st[c] = '0;
      return 1'b0;
    end
    case (link_st[c].phase)
      PH_HANDSHAKE: begin
        if (link_st[c].hs_count < 2'd2) begin
          link_st[c].hs_bytes = {link_st[c].hs_bytes[7:0], b};
          link_st[c].hs_count = link_st[c].hs_count + 2'd1;
          return 1'b0;
        end
        link_st[c].hs_count = '0;
        if (link_st[c].hs_bytes == {HS_FIRST, HS_SECOND}) begin
          link_st[c].hs_bytes = '0;
          if (b == HS_ACCEPT) begin
            link_st[c].phase = PH_LEN_HIGH;
            return 1'b0;
          end
          if (b == HS_REFUSE) begin
            link_st[c].phase = PH_CLOSING;
            res.kind = KIND_REFUSED;
            return 1'b1;
          end
        end
        link_st[c].hs_bytes = '0;
        res.kind = KIND_UNRECOGNIZED;
        return 1'b1;
      end
      PH_LEN_HIGH: begin
        link_st[c].frame_high = b;
        link_st[c].phase = PH_LEN_LOW;
        return 1'b0;
      end
      PH_LEN_LOW: begin
        len = {link_st[c].frame_high, b};
        link_st[c].frame_high = '0;
        if (len == 16'd0) begin
          link_st[c].phase = PH_LEN_HIGH;
          return 1'b0;
        end
        reach = {1'b0, link_st[c].msg_count} + 33'(len);
        if ((link_st[c].msg_count == 32'd0 && len < 16'd4) ||
            (link_st[c].msg_count != 32'd0 && reach > {1'b0, link_st[c].msg_total})) begin
          link_st[c].phase = PH_CLOSING;
          res.kind = KIND_MISMATCH;
          return 1'b1;
        end
        link_st[c].frame_length    = len;
        link_st[c].frame_remaining = len;
        link_st[c].phase = PH_PAYLOAD;
        return 1'b0;
      end
      PH_PAYLOAD: begin
        n = link_st[c].msg_count;
        if (n < 32'd4) begin
          link_st[c].msg_total = link_st[c].msg_total | (32'(b) << (8 * n));
          if (n == 32'd3 && (link_st[c].msg_total[31] ||
              link_st[c].msg_total < 32'(link_st[c].frame_length))) begin
            link_st[c].phase = PH_CLOSING;
            res.kind = KIND_MISMATCH;
            return 1'b1;
          end
        end
        n = n + 32'd1;
        link_st[c].msg_count = n;
        if (n >= 32'd4 && n == link_st[c].msg_total) begin
          res.last = 1'b1;
          link_st[c].msg_count = '0;
          link_st[c].msg_total = '0;
        end
        link_st[c].frame_remaining = link_st[c].frame_remaining - 16'd1;
        if (link_st[c].frame_remaining == 16'd0) begin
          link_st[c].phase = PH_LEN_HIGH;
        end
        res.data = b;
        return 1'b1;
      end
      default: begin
        skipped = 1'b1;
        return 1'b0;
      end
    endcase
  endfunction

  task automatic push_rx(input int c, input logic [7:0] b);
    conn_script[c].push_back('{1'b0, b});
  endtask

  task automatic push_len(input int c, input int len);
    logic [15:0] l;
    l = 16'(len);
    push_rx(c, l[15:8]);
    push_rx(c, l[7:0]);
  endtask

  // The first four message bytes carry the declared size, little-endian.
  task automatic push_payload(input int c, input int from, input int cnt, input logic [31:0] declared);
    for (int i = from; i < from + cnt; i++) begin
      if (i < 4) begin
        push_rx(c, declared[8*i +: 8]);
      end else begin
        push_rx(c, 8'($urandom));
      end
    end
  endtask

  task automatic push_noise(input int c);
    repeat ($urandom_range(0, 2)) push_rx(c, 8'($urandom));
  endtask

  // One session: a reset of the connection, a handshake, then a few messages, now and then broken.
  task automatic build_session(input int c);
    int mode;
    int sz;
    int first;
    int pos;
    int chunk;
    int brk;
    logic [31:0] declared;
    conn_script[c].push_back('{1'b1, 8'($urandom)});
    mode = $urandom_range(0, 19);
    if (mode == 0) begin
      repeat ($urandom_range(5, 15)) push_rx(c, 8'($urandom));
      return;
    end
    if (mode == 1) begin
      push_rx(c, HS_FIRST);
      push_rx(c, HS_SECOND);
      push_rx(c, HS_REFUSE);
      push_noise(c);
      return;
    end
    if (mode == 2) begin
      repeat (3) push_rx(c, 8'($urandom));
    end
    push_rx(c, HS_FIRST);
    push_rx(c, HS_SECOND);
    push_rx(c, HS_ACCEPT);
    repeat ($urandom_range(1, 4)) begin
      if ($urandom_range(0, 7) == 0) push_len(c, 0);
      sz  = $urandom_range(4, 14);
      brk = $urandom_range(0, 11);
      if ((brk == 0 || brk == 3) && sz < 5) sz = 5;
      declared = 32'(sz);
      first = $urandom_range(4, sz);
      if (brk == 0) begin
        first = sz;
        declared = 32'($urandom_range(0, sz - 1));
      end
      if (brk == 1) declared = {1'b1, 31'($urandom)};
      if (brk == 2) begin
        push_len(c, $urandom_range(1, 3));
        push_noise(c);
        return;
      end
      if (brk == 3 && first == sz) first = sz - 1;
      push_len(c, first);
      push_payload(c, 0, first, declared);
      if (brk <= 1) begin
        push_noise(c);
        return;
      end
      pos = first;
      if (brk == 3) begin
        push_len(c, $urandom_range(sz - first + 1, 65535));
        push_noise(c);
        return;
      end
      while (pos < sz) begin
        if ($urandom_range(0, 7) == 0) push_len(c, 0);
        chunk = $urandom_range(1, sz - pos);
        push_len(c, chunk);
        push_payload(c, pos, chunk, declared);
        pos = pos + chunk;
      end
    end
  endtask

  task automatic send_item(input logic cmd, input logic [1:0] c, input logic [7:0] rx,
                           input logic typed, input logic typed_has, input logic [1:0] typed_kind);
    int gap;
    bit got;
    bit skipped;
    deframe_result_t res;
    if (send_count % 40 == 0) send_calm = ($urandom_range(0, 3) == 0);
    send_count++;
    gap = send_calm ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= IN_TDATA_W'({rx, c});
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    got = deframe_byte(cmd, c, rx, res, skipped);
    if (!skipped) live_items++;
    if (typed) begin
      if (typed_has) expected_results.push_back('{c, typed_kind, 8'h00, 1'b0});
    end else if (got) begin
      expected_results.push_back(res);
    end
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (want !== got) begin
      errors++;
      if (errors <= 50) $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    deframe_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_results.size() == 0) begin
        errors++;
        if (errors <= 50) begin
          $display("%0t: transfer with none expected, expected none, actual tdata %0h tuser %0h tlast %0b",
                   $time, out_tdata, out_tuser, out_tlast);
        end
      end else begin
        want = expected_results.pop_front();
        check_field("source_connection", 8'(want.conn), 8'(out_tdata[1:0]));
        check_field("kind", 8'(want.kind), 8'(out_tuser));
        check_field("payload_byte", want.data, out_tdata[9:2]);
        check_field("message_last", 8'(want.last), 8'(out_tlast));
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    int gap;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (recv_count % 40 == 0) recv_calm = ($urandom_range(0, 3) == 0);
      recv_count++;
      if (hold_req) begin
        hold_req = 1'b0;
        gap = HOLD_CYCLES;
      end else begin
        gap = recv_calm ? 0 : $urandom_range(0, 11);
      end
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
    end
  end

  initial begin
    int c;
    bit held;
    bit paused;
    script_byte_t s;
    held   = 1'b0;
    paused = 1'b0;
    for (int i = 0; i < CONNECTIONS; i++) link_st[i] = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      send_item(dir_rows[i].cmd, dir_rows[i].conn, dir_rows[i].rx,
                dir_rows[i].typed, dir_rows[i].has_res, dir_rows[i].kind);
    end
    drain_results();

    live_items = 0;
    while (live_items < RANDOM_ITEMS) begin
      c = $urandom_range(0, CONNECTIONS - 1);
      if (conn_script[c].size() == 0) build_session(c);
      s = conn_script[c].pop_front();
      send_item(s.cmd, 2'(c), s.rx, 1'b0, 1'b0, KIND_PAYLOAD);
      // The receiver holds off for a long stretch while transfers keep being offered.
      if (!held && live_items >= 350) begin
        held = 1'b1;
        hold_req = 1'b1;
      end
      if (!paused && live_items >= 700) begin
        paused = 1'b1;
        drain_results();
      end
    end

    drain_results();
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

/* preamble_length_frame_deframer_top.f */
+incdir+src
src/plfd_pkg.sv
src/preamble_length_frame_deframer_top.sv
src/plfd_checker.sv
dv/preamble_length_frame_deframer_top_tb.sv
